@@ rtl/core/ibkl_pkg.sv @@
// Shared constants, codes and the pipeline transaction type of the key lookup block.
package ibkl_pkg;

    localparam int TREE_NODES_DEF = 1024;

    localparam int IDX_W  = 10;
    localparam int KEY_W  = 64;
    localparam int DATA_W = 64;
    localparam int KIND_W = 2;

    // node index widened so that every comparison against the tree size fits
    localparam int IDX_WIDE_W = 18;

    // stored node word: {kind, key, start, length}
    localparam int WORD_W = KIND_W + KEY_W + 2 * DATA_W;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    localparam logic [KIND_W-1:0] KIND_NORMAL   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TERMINAL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY    = 2'd2;

    // one transaction in flight; start and length carry the result once found
    typedef struct packed {
        logic              valid;
        logic              act;
        logic [IDX_W-1:0]  idx;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] start;
        logic [DATA_W-1:0] length;
        logic [KIND_W-1:0] kind;
        logic              done;
        logic              found;
    } t_item;

endpackage

@@ rtl/core/ibkl_if.sv @@
// Handshake interfaces for the request and result channels of the key lookup block.
interface ibkl_req_if
    import ibkl_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              action;
    logic [IDX_W-1:0]  node_index;
    logic [KEY_W-1:0]  search_key;
    logic [DATA_W-1:0] entry_start;
    logic [DATA_W-1:0] entry_length;
    logic [KIND_W-1:0] node_kind;

    modport source (
        output valid, action, node_index, search_key, entry_start, entry_length, node_kind,
        input  ready
    );
    modport sink (
        input  valid, action, node_index, search_key, entry_start, entry_length, node_kind,
        output ready
    );
endinterface

interface ibkl_rsp_if
    import ibkl_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              found;
    logic [DATA_W-1:0] found_start;
    logic [DATA_W-1:0] found_length;

    modport source (
        output valid, found, found_start, found_length,
        input  ready
    );
    modport sink (
        input  valid, found, found_start, found_length,
        output ready
    );
endinterface

@@ rtl/core/ibkl_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module ibkl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/core/ibkl_level.sv @@
// One tree level: its node store, an address stage, a data stage and the key compare.
module ibkl_level
    import ibkl_pkg::*;
#(
    parameter int LEVEL      = 0,
    parameter int TREE_NODES = TREE_NODES_DEF,
    parameter int CUR_W      = $clog2(TREE_NODES)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_clr_en,
    input  logic [CUR_W-2:0] i_clr_addr,
    input  t_item            i_item,
    input  logic [CUR_W-1:0] i_cur,
    output t_item            o_item,
    output logic [CUR_W-1:0] o_cur
);
    localparam int AW    = (LEVEL == 0) ? 1 : LEVEL;
    localparam int DEPTH = 2 ** AW;

    localparam logic [IDX_WIDE_W-1:0] LVL_LO = IDX_WIDE_W'(2 ** LEVEL);
    localparam logic [IDX_WIDE_W-1:0] LVL_HI = IDX_WIDE_W'(2 ** (LEVEL + 1));
    localparam logic [IDX_WIDE_W-1:0] LIMIT  = IDX_WIDE_W'(TREE_NODES);
    localparam logic [CUR_W:0]        CHILD_LIMIT = (CUR_W + 1)'(TREE_NODES);

    t_item            r_a;
    logic [CUR_W-1:0] r_a_cur;
    t_item            r_b;
    logic [CUR_W-1:0] r_b_cur;

    logic [IDX_WIDE_W-1:0] w_idx;
    logic                  w_hit;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [WORD_W-1:0]     w_wdata;
    logic [WORD_W-1:0]     w_rdata;

    logic [KIND_W-1:0] w_kind;
    logic [KEY_W-1:0]  w_key;
    logic [DATA_W-1:0] w_start;
    logic [DATA_W-1:0] w_length;
    logic [CUR_W:0]    w_child;

    // address stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
        end else if (i_adv) begin
            r_a     <= i_item;
            r_a_cur <= i_cur;
        end
    end

    // data stage, aligned with the registered read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.valid <= 1'b0;
        end else if (i_adv) begin
            r_b     <= r_a;
            r_b_cur <= r_a_cur;
        end
    end

    assign w_idx = IDX_WIDE_W'(r_a.idx);
    assign w_hit = (w_idx >= LVL_LO) && (w_idx < LVL_HI) && (w_idx < LIMIT);
    assign w_we  = i_clr_en || (i_adv && r_a.valid && (r_a.act == ACT_WRITE) && w_hit);

    always_comb begin
        if (i_clr_en) begin
            w_waddr = i_clr_addr[AW-1:0];
            w_wdata = {KIND_EMPTY, {(WORD_W - KIND_W){1'b0}}};
        end else begin
            w_waddr = w_idx[AW-1:0];
            w_wdata = {r_a.kind, r_a.key, r_a.start, r_a.length};
        end
    end

    ibkl_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_adv),
        .i_raddr (r_a_cur[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign {w_kind, w_key, w_start, w_length} = w_rdata;
    assign w_child = {r_b_cur, (r_b.key > w_key)};

    always_comb begin
        o_item = r_b;
        o_cur  = r_b_cur;
        if (r_b.valid && !r_b.done) begin
            if (!(w_kind inside {KIND_NORMAL, KIND_TERMINAL})) begin
                o_item.done = 1'b1;
            end else if (r_b.key == w_key) begin
                o_item.done   = 1'b1;
                o_item.found  = 1'b1;
                o_item.start  = w_start;
                o_item.length = w_length;
            end else if (w_kind == KIND_TERMINAL) begin
                o_item.done = 1'b1;
            end else if (w_child >= CHILD_LIMIT) begin
                // drop off the end of the table
                o_item.done = 1'b1;
            end else begin
                o_cur = w_child[CUR_W-1:0];
            end
        end
    end
endmodule

@@ rtl/core/implicit_bst_key_lookup.sv @@
// Top level of the implicit binary search tree key lookup block.
// The tree is held one level per pipeline section, each level in its own RAM, so a lookup
// reads exactly one node per level and one transaction (a node write or a lookup) can be
// accepted in every cycle while the pipeline advances. Each level registers the transaction
// in an address stage and in a data stage aligned with its registered RAM read, and a result
// register follows the last level. A node write takes effect in its level's RAM as it passes,
// so every later transaction sees it and every earlier one does not. After reset the block
// clears all node kinds to empty and takes no transaction until that is done. The whole
// pipeline halts while a result waits to be taken.
module implicit_bst_key_lookup
    import ibkl_pkg::*;
#(
    parameter int TREE_NODES = TREE_NODES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ibkl_req_if.sink   i_lookup,
    ibkl_rsp_if.source o_result
);
    localparam int LEVELS = $clog2(TREE_NODES);
    localparam int CLR_W  = LEVELS - 1;

    t_item            w_item [LEVELS + 1];
    logic [LEVELS-1:0] w_cur [LEVELS + 1];

    logic              w_adv;
    logic              r_clearing;
    logic [CLR_W-1:0]  r_clr;
    logic              r_out_valid;
    logic              r_out_found;
    logic [DATA_W-1:0] r_out_start;
    logic [DATA_W-1:0] r_out_length;
    logic              n_out_found;

    // advance everything unless a result is held back
    assign w_adv          = !r_out_valid || o_result.ready;
    assign i_lookup.ready = w_adv && !r_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr      <= '0;
        end else if (r_clearing) begin
            r_clr <= r_clr + 1'b1;
            if (r_clr == {CLR_W{1'b1}}) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_comb begin
        w_item[0].valid  = i_lookup.valid && i_lookup.ready;
        w_item[0].act    = i_lookup.action;
        w_item[0].idx    = i_lookup.node_index;
        w_item[0].key    = i_lookup.search_key;
        w_item[0].start  = i_lookup.entry_start;
        w_item[0].length = i_lookup.entry_length;
        w_item[0].kind   = i_lookup.node_kind;
        // writes need no search
        w_item[0].done   = (i_lookup.action == ACT_WRITE);
        w_item[0].found  = 1'b0;
        w_cur[0]         = LEVELS'(1);
    end

    for (genvar g = 0; g < LEVELS; g++) begin : g_level
        ibkl_level #(
            .LEVEL      (g),
            .TREE_NODES (TREE_NODES),
            .CUR_W      (LEVELS)
        ) u_level (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_adv      (w_adv),
            .i_clr_en   (r_clearing),
            .i_clr_addr (r_clr),
            .i_item     (w_item[g]),
            .i_cur      (w_cur[g]),
            .o_item     (w_item[g + 1]),
            .o_cur      (w_cur[g + 1])
        );
    end

    assign n_out_found = w_item[LEVELS].found && (w_item[LEVELS].act == ACT_LOOKUP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_item[LEVELS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_found  <= n_out_found;
            r_out_start  <= n_out_found ? w_item[LEVELS].start : '0;
            r_out_length <= n_out_found ? w_item[LEVELS].length : '0;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.found        = r_out_found;
    assign o_result.found_start  = r_out_start;
    assign o_result.found_length = r_out_length;
endmodule
